// ===== rtl/saps_pkg.sv =====
// shared types and constants for the symbol address predecessor search block
package saps_pkg;

   localparam int TABLE_DEPTH   = 4096;
   localparam int IDX_W         = $clog2(TABLE_DEPTH);
   localparam int CNT_W         = IDX_W + 1;
   localparam int ADDR_W        = 64;
   localparam int TYPE_W        = 8;
   localparam int ENTRY_INDEX_W = 12;
   localparam int ENTRY_W       = ADDR_W + 1;

   localparam logic [TYPE_W-1:0] SYM_FUNC_LOWER = 8'h74;  // 't'
   localparam logic [TYPE_W-1:0] SYM_FUNC_UPPER = 8'h54;  // 'T'

   typedef enum logic [1:0] {
      OP_CLEAR  = 2'd0,
      OP_APPEND = 2'd1,
      OP_LOOKUP = 2'd2,
      OP_NOP    = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_FULL      = 2'd2,
      ST_ORDER     = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_SEARCH,
      S_RD_LO,
      S_RD_NXT,
      S_FIN,
      S_DONE
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic capture;
      logic exec;
      logic search;
      logic rd_lo;
      logic rd_nxt;
      logic fin;
      logic publish;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic lookup_go;
      logic search_done;
      logic out_free;
   } stat_type;

endpackage

// ===== rtl/symbol_address_predecessor_search.sv =====
// top level: symbol address table with binary-search predecessor lookup
// clear, append and unused codes: executed and published without a search
// lookup: binary search, then the match and its follower are fetched; the search probes
//   number ceil of log2 of the entry count, 12 for a full 4096-entry table
// one word in flight at a time; the next word is taken the cycle after the result enters
//   the output register, even while that result waits for rsp_ready
// synchronous active-high reset empties the table and drops any pending result
module symbol_address_predecessor_search import saps_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   // request words
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [1:0]               req_operation,
   input  logic [ADDR_W-1:0]        req_address,
   input  logic [TYPE_W-1:0]        req_symbol_type,
   // response words
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [1:0]               rsp_status,
   output logic [ENTRY_INDEX_W-1:0] rsp_entry_index,
   output logic [ADDR_W-1:0]        rsp_entry_address,
   output logic                     rsp_entry_is_function,
   output logic [ADDR_W-1:0]        rsp_function_size
);

   // command and status between controller and datapath
   cmd_type  cmd;
   stat_type stat;

   // state machine: idle, execute, search, fetch match and follower, publish
   saps_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // table ram, search indexes, size subtract, output register
   saps_dp u_dp (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .stat                  (stat),
      .req_operation         (req_operation),
      .req_address           (req_address),
      .req_symbol_type       (req_symbol_type),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_status            (rsp_status),
      .rsp_entry_index       (rsp_entry_index),
      .rsp_entry_address     (rsp_entry_address),
      .rsp_entry_is_function (rsp_entry_is_function),
      .rsp_function_size     (rsp_function_size)
   );

   // an accepted word keeps the block busy in the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while previous word still in work");

   // a response only appears after the controller publishes one
   a_rsp_from_publish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(cmd.publish))
      else $error("response valid without publish");

   // publishing never overwrites a response still waiting
   a_publish_free: assert property (@(posedge clock) disable iff (reset)
      cmd.publish |-> (!rsp_valid || rsp_ready))
      else $error("publish into an occupied output register");

endmodule

// ===== rtl/saps_ram.sv =====
// generic single-port-write, single-port-read ram with registered read
module saps_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/saps_dp.sv =====
// datapath: entry table, search indexes, result and output word registers
module saps_dp import saps_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  cmd_type                  cmd,
   output stat_type                 stat,
   input  logic [1:0]               req_operation,
   input  logic [ADDR_W-1:0]        req_address,
   input  logic [TYPE_W-1:0]        req_symbol_type,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [1:0]               rsp_status,
   output logic [ENTRY_INDEX_W-1:0] rsp_entry_index,
   output logic [ADDR_W-1:0]        rsp_entry_address,
   output logic                     rsp_entry_is_function,
   output logic [ADDR_W-1:0]        rsp_function_size
);

   // captured word
   op_type              op_ff;
   logic [ADDR_W-1:0]   query_ff;
   logic [TYPE_W-1:0]   type_ff;

   // table bookkeeping
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [ADDR_W-1:0]   last_ff, last_in;

   // search state
   logic [IDX_W-1:0]    lo_ff, hi_ff, mid_ff;
   logic [IDX_W-1:0]    lo_cur, hi_cur, mid_in;
   logic                pend_ff, pend_in;
   logic [CNT_W-1:0]    span;
   logic                cmp_le;

   // matched entry
   logic [ADDR_W-1:0]   lo_addr_ff;
   logic                lo_kind_ff;

   // staged result
   status_type               res_status_ff;
   logic [ENTRY_INDEX_W-1:0] res_index_ff;
   logic [ADDR_W-1:0]        res_address_ff;
   logic                     res_func_ff;
   logic [ADDR_W-1:0]        res_size_ff;
   status_type               exec_status;

   // output word
   logic                     rsp_valid_ff;
   logic [1:0]               rsp_status_ff;
   logic [ENTRY_INDEX_W-1:0] rsp_index_ff;
   logic [ADDR_W-1:0]        rsp_address_ff;
   logic                     rsp_func_ff;
   logic [ADDR_W-1:0]        rsp_size_ff;

   // ram
   logic                ram_wr_en, ram_rd_en;
   logic [IDX_W-1:0]    ram_rd_addr;
   logic [ENTRY_W-1:0]  ram_rd_data;
   logic [ADDR_W-1:0]   rd_addr_val;
   logic                rd_kind;

   logic                is_func;
   logic                tbl_full, out_of_order;
   logic                nxt_valid;

   assign rd_addr_val = ram_rd_data[ADDR_W-1:0];
   assign rd_kind     = ram_rd_data[ADDR_W];

   assign is_func      = (type_ff == SYM_FUNC_LOWER) || (type_ff == SYM_FUNC_UPPER);
   assign tbl_full     = (count_ff == CNT_W'(TABLE_DEPTH));
   assign out_of_order = (count_ff != '0) && (query_ff < last_ff);
   assign ram_wr_en    = cmd.exec && (op_ff == OP_APPEND) && !tbl_full && !out_of_order;

   // one halving step per cycle; the previous probe's data arrives when pend_ff is set
   assign cmp_le = (rd_addr_val <= query_ff);

   always_comb begin
      lo_cur = lo_ff;
      hi_cur = hi_ff;
      if (pend_ff) begin
         if (cmp_le) begin
            lo_cur = mid_ff;
         end else begin
            hi_cur = mid_ff - IDX_W'(1);
         end
      end
      span   = {1'b0, hi_cur} - {1'b0, lo_cur} + CNT_W'(1);
      mid_in = lo_cur + span[CNT_W-1:1];
   end

   assign stat.search_done = !(lo_cur < hi_cur);
   assign stat.lookup_go   = (op_ff == OP_LOOKUP) && (count_ff != '0);
   assign stat.out_free    = !rsp_valid_ff || rsp_ready;

   always_comb begin
      ram_rd_addr = mid_in;
      if (cmd.rd_lo) begin
         ram_rd_addr = lo_ff;
      end else if (cmd.rd_nxt) begin
         ram_rd_addr = lo_ff + IDX_W'(1);
      end
   end

   assign ram_rd_en = (cmd.search && !stat.search_done) || cmd.rd_lo || cmd.rd_nxt;

   saps_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data ({is_func, query_ff}),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign nxt_valid = (({1'b0, lo_ff} + CNT_W'(1)) < count_ff);

   // bookkeeping next values
   always_comb begin
      count_in = count_ff;
      last_in  = last_ff;
      if (cmd.exec && (op_ff == OP_CLEAR)) begin
         count_in = '0;
         last_in  = '0;
      end else if (ram_wr_en) begin
         count_in = count_ff + CNT_W'(1);
         last_in  = query_ff;
      end
   end

   always_comb begin
      pend_in = pend_ff;
      if (cmd.exec) begin
         pend_in = 1'b0;
      end else if (cmd.search) begin
         pend_in = !stat.search_done;
      end
   end

   // status decided in the execute cycle; a lookup on a filled table gets its final status at fin
   always_comb begin
      exec_status = ST_OK;
      case (op_ff)
         OP_APPEND: begin
            if (tbl_full) begin
               exec_status = ST_FULL;
            end else if (out_of_order) begin
               exec_status = ST_ORDER;
            end
         end
         OP_LOOKUP: begin
            if (count_ff == '0) begin
               exec_status = ST_NOT_FOUND;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         last_ff      <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         last_ff  <= last_in;
         pend_ff  <= pend_in;
         if (cmd.publish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff    <= op_type'(req_operation);
         query_ff <= req_address;
         type_ff  <= req_symbol_type;
      end

      // only a stored append reports an entry here
      if (cmd.exec) begin
         lo_ff          <= '0;
         hi_ff          <= IDX_W'(count_ff - CNT_W'(1));
         res_status_ff  <= exec_status;
         res_index_ff   <= ram_wr_en ? ENTRY_INDEX_W'(count_ff) : '0;
         res_address_ff <= ram_wr_en ? query_ff : '0;
         res_func_ff    <= ram_wr_en && is_func;
         res_size_ff    <= '0;
      end

      if (cmd.search) begin
         lo_ff  <= lo_cur;
         hi_ff  <= hi_cur;
         mid_ff <= mid_in;
      end

      if (cmd.rd_nxt) begin
         lo_addr_ff <= rd_addr_val;
         lo_kind_ff <= rd_kind;
      end

      // ram now holds the entry after the match
      if (cmd.fin) begin
         if (lo_addr_ff > query_ff) begin
            res_status_ff  <= ST_NOT_FOUND;
            res_index_ff   <= '0;
            res_address_ff <= '0;
            res_func_ff    <= 1'b0;
            res_size_ff    <= '0;
         end else begin
            res_status_ff  <= ST_OK;
            res_index_ff   <= ENTRY_INDEX_W'(lo_ff);
            res_address_ff <= lo_addr_ff;
            res_func_ff    <= lo_kind_ff;
            res_size_ff    <= (lo_kind_ff && nxt_valid && rd_kind) ?
                              (rd_addr_val - lo_addr_ff) : '0;
         end
      end

      if (cmd.publish) begin
         rsp_status_ff  <= res_status_ff;
         rsp_index_ff   <= res_index_ff;
         rsp_address_ff <= res_address_ff;
         rsp_func_ff    <= res_func_ff;
         rsp_size_ff    <= res_size_ff;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_status            = rsp_status_ff;
   assign rsp_entry_index       = rsp_index_ff;
   assign rsp_entry_address     = rsp_address_ff;
   assign rsp_entry_is_function = rsp_func_ff;
   assign rsp_function_size     = rsp_size_ff;

endmodule

// ===== rtl/saps_ctrl.sv =====
// controller: sequences one word through execute, search, fetch and publish
module saps_ctrl import saps_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  stat_type stat,
   output cmd_type  cmd
);

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = stat.lookup_go ? S_SEARCH : S_DONE;
         end
         S_SEARCH: begin
            if (stat.search_done) begin
               state_in = S_RD_LO;
            end
         end
         S_RD_LO:  state_in = S_RD_NXT;
         S_RD_NXT: state_in = S_FIN;
         S_FIN:    state_in = S_DONE;
         S_DONE: begin
            if (stat.out_free) begin
               state_in = S_IDLE;
            end
         end
         default:  state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         S_EXEC:   cmd.exec   = 1'b1;
         S_SEARCH: cmd.search = 1'b1;
         S_RD_LO:  cmd.rd_lo  = 1'b1;
         S_RD_NXT: cmd.rd_nxt = 1'b1;
         S_FIN:    cmd.fin    = 1'b1;
         S_DONE:   cmd.publish = stat.out_free;
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== tb/sv/tb_top.sv =====
// self-checking bench for the symbol address predecessor search block
module tb_top;
   import saps_pkg::*;

   // request and result words as the bench sees them
   typedef struct packed {
      op_type                   op;
      logic [ADDR_W-1:0]        address;
      logic [TYPE_W-1:0]        symbol_type;
   } sym_request_type;

   typedef struct packed {
      status_type               status;
      logic [ENTRY_INDEX_W-1:0] entry_index;
      logic [ADDR_W-1:0]        entry_address;
      logic                     entry_is_function;
      logic [ADDR_W-1:0]        function_size;
   } lookup_result_type;

   localparam logic [ADDR_W-1:0] ADDR_MAX    = '1;
   localparam logic [TYPE_W-1:0] TYPE_DATA   = 8'h64;  // 'd', plain data symbol
   localparam int                STALL_LIMIT = 2000;   // cycles with no word moving
   localparam int                PHASE_WORDS = 155;    // random words per idling phase
   localparam int                NUM_PHASES  = 8;

   logic                     clock;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic [1:0]               req_operation = '0;
   logic [ADDR_W-1:0]        req_address = '0;
   logic [TYPE_W-1:0]        req_symbol_type = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic [1:0]               rsp_status;
   logic [ENTRY_INDEX_W-1:0] rsp_entry_index;
   logic [ADDR_W-1:0]        rsp_entry_address;
   logic                     rsp_entry_is_function;
   logic [ADDR_W-1:0]        rsp_function_size;

   symbol_address_predecessor_search dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_operation         (req_operation),
      .req_address           (req_address),
      .req_symbol_type       (req_symbol_type),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_status            (rsp_status),
      .rsp_entry_index       (rsp_entry_index),
      .rsp_entry_address     (rsp_entry_address),
      .rsp_entry_is_function (rsp_entry_is_function),
      .rsp_function_size     (rsp_function_size)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // ---------------------------------------------------------------------------
   // symbol table mirror, updated once per accepted request word
   // ---------------------------------------------------------------------------
   logic [ADDR_W-1:0] tbl_addr [TABLE_DEPTH];
   logic              tbl_func [TABLE_DEPTH];
   int                tbl_count = 0;
   logic [ADDR_W-1:0] tbl_last = '0;

   lookup_result_type expected_results [$];
   sym_request_type   request_words [$];
   sym_request_type   cur_word;
   lookup_result_type due_word;

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int mismatches     = 0;
   int sent_words     = 0;
   int quiet_cycles   = 0;

   // predicts the result word of one request and advances the table
   function automatic lookup_result_type resolve_word(sym_request_type w);
      lookup_result_type r;
      logic              fn;
      int                lo;
      int                hi;
      int                mid;
      r = '0;
      case (w.op)
         OP_CLEAR: begin
            tbl_count = 0;
            tbl_last  = '0;
         end
         OP_APPEND: begin
            if (tbl_count >= TABLE_DEPTH) begin
               r.status = ST_FULL;
            end else if (tbl_count > 0 && w.address < tbl_last) begin
               // refused: the table must stay sorted for the search
               r.status = ST_ORDER;
            end else begin
               fn = (w.symbol_type == SYM_FUNC_LOWER) || (w.symbol_type == SYM_FUNC_UPPER);
               tbl_addr[tbl_count]   = w.address;
               tbl_func[tbl_count]   = fn;
               r.entry_index         = ENTRY_INDEX_W'(tbl_count);
               r.entry_address       = w.address;
               r.entry_is_function   = fn;
               tbl_count++;
               tbl_last = w.address;
            end
         end
         OP_LOOKUP: begin
            if (tbl_count == 0) begin
               r.status = ST_NOT_FOUND;
            end else begin
               // last entry at or below the query
               lo = 0;
               hi = tbl_count - 1;
               while (lo < hi) begin
                  mid = lo + (hi - lo + 1) / 2;
                  if (tbl_addr[mid] <= w.address) lo = mid;
                  else hi = mid - 1;
               end
               if (tbl_addr[lo] > w.address) begin
                  r.status = ST_NOT_FOUND;
               end else begin
                  r.entry_index       = ENTRY_INDEX_W'(lo);
                  r.entry_address     = tbl_addr[lo];
                  r.entry_is_function = tbl_func[lo];
                  // size only between two adjacent function entries
                  if (tbl_func[lo] && lo + 1 < tbl_count && tbl_func[lo + 1])
                     r.function_size = tbl_addr[lo + 1] - tbl_addr[lo];
               end
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   // ---------------------------------------------------------------------------
   // driver: presents queued request words, predicts on acceptance
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready)
            expected_results.push_back(resolve_word(cur_word));
         // slot is free when nothing is shown or the shown word just went in
         if (!req_valid || req_ready) begin
            if (request_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               cur_word         = request_words.pop_front();
               req_valid       <= 1'b1;
               req_operation   <= cur_word.op;
               req_address     <= cur_word.address;
               req_symbol_type <= cur_word.symbol_type;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------------
   // monitor: checks each result word against the oldest prediction
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("result word with nothing pending: status %0d index %0d address %h",
                           rsp_status, rsp_entry_index, rsp_entry_address);
            end else begin
               due_word = expected_results.pop_front();
               if (rsp_status !== due_word.status ||
                   rsp_entry_index !== due_word.entry_index ||
                   rsp_entry_address !== due_word.entry_address ||
                   rsp_entry_is_function !== due_word.entry_is_function ||
                   rsp_function_size !== due_word.function_size) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("mismatch: expected status %0d index %0d address %h func %0b size %h",
                              due_word.status, due_word.entry_index, due_word.entry_address,
                              due_word.entry_is_function, due_word.function_size);
                     $display("          got      status %0d index %0d address %h func %0b size %h",
                              rsp_status, rsp_entry_index, rsp_entry_address,
                              rsp_entry_is_function, rsp_function_size);
                  end
               end
            end
         end
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // watchdog: the run is hung when no word moves on either side for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------------
   // stimulus side: own view of the table, only used to aim queries
   // ---------------------------------------------------------------------------
   logic [ADDR_W-1:0] gen_addrs [$];

   task automatic send(op_type op, logic [ADDR_W-1:0] a, logic [TYPE_W-1:0] ty);
      sym_request_type w;
      w.op          = op;
      w.address     = a;
      w.symbol_type = ty;
      request_words.push_back(w);
      sent_words++;
      case (op)
         OP_CLEAR: gen_addrs.delete();
         OP_APPEND: begin
            if (gen_addrs.size() < TABLE_DEPTH && (gen_addrs.size() == 0 || a >= gen_addrs[$]))
               gen_addrs.push_back(a);
         end
         default: ;
      endcase
   endtask

   function automatic logic [ADDR_W-1:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // mostly function symbols, so sizes between neighbors come up often
   function automatic logic [TYPE_W-1:0] func_type();
      case ($urandom_range(9))
         0, 1, 2: return SYM_FUNC_LOWER;
         3, 4:    return SYM_FUNC_UPPER;
         5:       return TYPE_DATA;
         default: return TYPE_W'($urandom);
      endcase
   endfunction

   // next ascending address, repeats allowed, saturating at the top
   function automatic logic [ADDR_W-1:0] step_up(logic [ADDR_W-1:0] a);
      logic [ADDR_W-1:0] d;
      logic [ADDR_W:0]   s;
      case ($urandom_range(9))
         0:             d = '0;
         1, 2, 3, 4:    d = ADDR_W'($urandom_range(64, 1));
         5, 6:          d = ADDR_W'($urandom_range(32'h000F_FFFF, 1));
         7, 8:          d = {32'h0, $urandom};
         default:       d = rand64() >> $urandom_range(63, 4);
      endcase
      s = {1'b0, a} + {1'b0, d};
      return s[ADDR_W] ? ADDR_MAX : s[ADDR_W-1:0];
   endfunction

   // query aimed at, just past or just before a known entry, or anywhere
   function automatic logic [ADDR_W-1:0] pick_query();
      logic [ADDR_W-1:0] e;
      if (gen_addrs.size() == 0 || $urandom_range(7) == 0) begin
         case ($urandom_range(3))
            0:       return '0;
            1:       return ADDR_MAX;
            default: return rand64() >> $urandom_range(63);
         endcase
      end
      e = gen_addrs[$urandom_range(gen_addrs.size() - 1)];
      case ($urandom_range(4))
         0:       return e;
         1:       return e + $urandom_range(16, 1);
         2:       return e - 1;
         3:       return e + {32'h0, $urandom};
         default: return rand64();
      endcase
   endfunction

   // one stretch of random traffic, mostly clear / fill / search sequences
   task automatic random_sequence();
      logic [ADDR_W-1:0] a;
      int                n;
      int                m;
      int                kind;
      kind = $urandom_range(9);
      if (kind <= 5) begin
         // mostly well-formed: optional clear, ascending appends with an occasional lower one, then lookups
         if ($urandom_range(4) != 0) begin
            send(OP_CLEAR, rand64(), TYPE_W'($urandom));
            case ($urandom_range(3))
               0:       a = '0;
               1:       a = ADDR_MAX - $urandom_range(200);
               default: a = rand64() >> $urandom_range(63);
            endcase
         end else begin
            a = (gen_addrs.size() != 0) ? gen_addrs[$] : '0;
         end
         n = ($urandom_range(15) == 0) ? $urandom_range(200, 41) : $urandom_range(40, 1);
         for (int i = 0; i < n; i++) begin
            if (gen_addrs.size() != 0 && gen_addrs[$] != 0 && $urandom_range(19) == 0)
               send(OP_APPEND, rand64() % gen_addrs[$], func_type());  // below the last one
            send(OP_APPEND, a, func_type());
            a = step_up(a);
         end
         m = $urandom_range((n < 20) ? 2 * n + 4 : 50, 1);
         for (int i = 0; i < m; i++)
            send(OP_LOOKUP, pick_query(), TYPE_W'($urandom));
      end else if (kind == 6) begin
         // noise: any code, any address, any type
         n = $urandom_range(12, 1);
         for (int i = 0; i < n; i++)
            send(op_type'($urandom_range(3)), rand64() >> ($urandom_range(1) * $urandom_range(63)),
                 TYPE_W'($urandom));
      end else if (kind == 7) begin
         n = $urandom_range(20, 1);
         for (int i = 0; i < n; i++)
            send(OP_LOOKUP, pick_query(), TYPE_W'($urandom));
      end else begin
         // appends and lookups interleaved on the live table
         a = (gen_addrs.size() != 0) ? gen_addrs[$] : rand64() >> $urandom_range(63);
         n = $urandom_range(30, 2);
         for (int i = 0; i < n; i++) begin
            if ($urandom_range(1)) begin
               a = step_up(a);
               send(OP_APPEND, a, func_type());
            end else begin
               send(OP_LOOKUP, pick_query(), TYPE_W'($urandom));
            end
         end
      end
   endtask

   task automatic wait_drained();
      while (request_words.size() != 0 || req_valid)
         @(negedge clock);
   endtask

   // ---------------------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------------------
   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed words: empty table, equal and refused appends, top address,
      // below-first query, data neighbor, unused code, clear
      send(OP_LOOKUP, '0, '0);
      send(OP_LOOKUP, ADDR_MAX, '1);
      send(OP_NOP, ADDR_MAX, '1);
      send(OP_APPEND, 64'h100, SYM_FUNC_LOWER);
      send(OP_APPEND, 64'h100, SYM_FUNC_UPPER);
      send(OP_APPEND, 64'h180, TYPE_DATA);
      send(OP_APPEND, 64'h200, SYM_FUNC_LOWER);
      send(OP_APPEND, 64'h0FF, SYM_FUNC_LOWER);
      send(OP_APPEND, ADDR_MAX, SYM_FUNC_UPPER);
      send(OP_LOOKUP, 64'h0FF, '0);
      send(OP_LOOKUP, 64'h100, '0);
      send(OP_LOOKUP, 64'h17F, '0);
      send(OP_LOOKUP, 64'h180, '0);
      send(OP_LOOKUP, 64'h1FF, '0);
      send(OP_LOOKUP, 64'h200, '0);
      send(OP_LOOKUP, ADDR_MAX, '0);
      send(OP_NOP, '0, '0);
      send(OP_CLEAR, ADDR_MAX, '1);
      send(OP_LOOKUP, 64'h200, '0);
      send(OP_APPEND, '0, SYM_FUNC_UPPER);
      send(OP_APPEND, 64'h5, SYM_FUNC_LOWER);
      send(OP_LOOKUP, '0, '0);
      send(OP_LOOKUP, ADDR_MAX, '0);
      send(OP_CLEAR, '0, '0);
      send(OP_LOOKUP, 64'h5, '0);
      wait_drained();

      // random traffic over the idling phases: none, sender, receiver, both
      for (int p = 0; p < NUM_PHASES; p++) begin
         int start;
         case (p % 4)
            0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1:       begin send_idle_pct = 45; recv_stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  recv_stall_pct = 45; end
            default: begin send_idle_pct = 24; recv_stall_pct = 24; end
         endcase
         start = sent_words;
         while (sent_words - start < PHASE_WORDS)
            random_sequence();
         wait_drained();
      end

      // let the last results come back, then allow for the longest search
      while (expected_results.size() != 0)
         @(negedge clock);
      repeat (40) @(negedge clock);

      if (expected_results.size() != 0)
         $display("%0d result words never arrived", expected_results.size());
      if (mismatches == 0 && expected_results.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
